[rtl/fdot_pkg.sv]
// fdot_pkg: shared constants, register codes and small types for the frame
// difference object tracker; no dependencies, compiled first
package fdot_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF  = 12;
    localparam int SPEED_FRAC_DEF  = 8;

    // fixed field widths
    localparam int PIX_BITS        = 8;
    localparam int TIME_BITS       = 10;
    localparam int THR_BITS        = 8;
    localparam int AREA_REG_BITS   = 25;
    localparam int SPEED_BITS      = 20;

    // configuration port
    localparam int DATA_BITS       = 32;
    localparam int ADDR_BITS       = 5;
    localparam int REG_IDX_BITS    = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_DIFF_THR = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_MIN_AREA = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MAX_AREA = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_START_X  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_START_Y  = 3'd4;

    // register reset values
    localparam logic [THR_BITS-1:0]      THR_RST      = 8'd20;
    localparam logic [AREA_REG_BITS-1:0] MIN_AREA_RST = 25'd1000;
    localparam logic [AREA_REG_BITS-1:0] MAX_AREA_RST = 25'd60000;
    localparam int                       START_X_RST  = 645;
    localparam int                       START_Y_RST  = 1062;

    // time stamp handling
    localparam logic [TIME_BITS-1:0] TIME_LAST = 10'd999;
    localparam logic [TIME_BITS:0]   TIME_WRAP = 11'd1000;

    // speed scaling: 10 / 17.25 = 40 / 69, radicand scaled by (2 * 40)^2
    localparam int                         DEN_BITS       = 17;
    localparam logic [DEN_BITS-1:0]        DIST_DEN       = 17'd69;
    localparam int                         RAD_SCALE_BITS = 13;
    localparam logic [RAD_SCALE_BITS-1:0]  RAD_SCALE      = 13'd6400;
    localparam logic [SPEED_BITS-1:0]      SPEED_MAX      = '1;

    // frame record queue
    localparam int FIFO_DEPTH = 2;

    // area limits handed to the back end
    typedef struct packed {
        logic [AREA_REG_BITS-1:0] min_area;
        logic [AREA_REG_BITS-1:0] max_area;
    } t_area_lim;

    // last-position load strobes from the register block
    typedef struct packed {
        logic load_x;
        logic load_y;
    } t_prev_load;

endpackage

[rtl/fdot_if.sv]
// fdot_if: valid/ready channels for pixel words and result words
// depends on fdot_pkg for field widths
interface fdot_pix_if #(
    parameter int COORD_BITS = fdot_pkg::COORD_BITS_DEF
);
    import fdot_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PIX_BITS-1:0]   current_pixel;
    logic [PIX_BITS-1:0]   background_pixel;
    logic                  in_mask;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  frame_end;
    logic [TIME_BITS-1:0]  time_ms;

    modport source (
        output valid, current_pixel, background_pixel, in_mask,
               pixel_x, pixel_y, frame_end, time_ms,
        input  ready
    );
    modport sink (
        input  valid, current_pixel, background_pixel, in_mask,
               pixel_x, pixel_y, frame_end, time_ms,
        output ready
    );
endinterface

interface fdot_res_if #(
    parameter int COORD_BITS = fdot_pkg::COORD_BITS_DEF
);
    import fdot_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS:0]   box_width;
    logic [COORD_BITS:0]   box_height;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [SPEED_BITS-1:0] speed_q8;

    modport source (
        output valid, found, box_left, box_top, box_width, box_height,
               center_x, center_y, speed_q8,
        input  ready
    );
    modport sink (
        input  valid, found, box_left, box_top, box_width, box_height,
               center_x, center_y, speed_q8,
        output ready
    );
endinterface

[rtl/fdot_front.sv]
// fdot_front: classifies pixels as foreground and keeps the running box,
// pushes one frame record per frame end; depends on fdot_pkg, fdot_pix_if
module fdot_front #(
    parameter int COORD_BITS = fdot_pkg::COORD_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    fdot_pix_if.sink                                      i_pix,
    input  logic [fdot_pkg::THR_BITS-1:0]                 i_thr,
    input  logic                                          i_full,
    output logic                                          o_push,
    output logic [4*COORD_BITS+fdot_pkg::TIME_BITS:0]     o_rec
);
    import fdot_pkg::*;

    logic [COORD_BITS-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic                  r_any;
    logic [COORD_BITS-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic                  n_any;
    logic [PIX_BITS-1:0]   diff;
    logic                  fg;
    logic                  accept;
    logic [TIME_BITS-1:0]  time_clamp;

    // take a word whenever the queue has room for a frame record
    assign i_pix.ready = !i_full;
    assign accept      = i_pix.valid && i_pix.ready;

    // foreground test
    always_comb begin
        diff = (i_pix.current_pixel > i_pix.background_pixel)
             ? i_pix.current_pixel - i_pix.background_pixel
             : i_pix.background_pixel - i_pix.current_pixel;
        fg   = i_pix.in_mask && (diff > i_thr);
    end

    // box including this pixel
    always_comb begin
        n_min_x    = (fg && i_pix.pixel_x < r_min_x) ? i_pix.pixel_x : r_min_x;
        n_max_x    = (fg && i_pix.pixel_x > r_max_x) ? i_pix.pixel_x : r_max_x;
        n_min_y    = (fg && i_pix.pixel_y < r_min_y) ? i_pix.pixel_y : r_min_y;
        n_max_y    = (fg && i_pix.pixel_y > r_max_y) ? i_pix.pixel_y : r_max_y;
        n_any      = r_any || fg;
        time_clamp = (i_pix.time_ms > TIME_LAST) ? TIME_LAST : i_pix.time_ms;
    end

    // frame record out on the frame end word
    assign o_push = accept && i_pix.frame_end;
    assign o_rec  = {n_any, n_min_x, n_max_x, n_min_y, n_max_y, time_clamp};

    // running box, cleared after each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '1;
            r_max_x <= '0;
            r_min_y <= '1;
            r_max_y <= '0;
            r_any   <= 1'b0;
        end else if (accept) begin
            if (i_pix.frame_end) begin
                r_min_x <= '1;
                r_max_x <= '0;
                r_min_y <= '1;
                r_max_y <= '0;
                r_any   <= 1'b0;
            end else begin
                r_min_x <= n_min_x;
                r_max_x <= n_max_x;
                r_min_y <= n_min_y;
                r_max_y <= n_max_y;
                r_any   <= n_any;
            end
        end
    end

endmodule

[rtl/fdot_fifo.sv]
// fdot_fifo: short first-in first-out queue of frame records between the
// front and back ends; depends on nothing but its parameters
module fdot_fifo #(
    parameter int WIDTH = 59,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/fdot_back.sv]
// fdot_back: per-frame evaluation of box, area window, centre and speed
// with bit-serial square root and divider; depends on fdot_pkg, fdot_res_if
module fdot_back #(
    parameter int COORD_BITS      = fdot_pkg::COORD_BITS_DEF,
    parameter int SPEED_FRAC_BITS = fdot_pkg::SPEED_FRAC_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_rec_valid,
    input  logic [4*COORD_BITS+fdot_pkg::TIME_BITS:0] i_rec,
    output logic                                      o_pop,
    input  fdot_pkg::t_area_lim                       i_lim,
    input  fdot_pkg::t_prev_load                      i_load,
    input  logic [COORD_BITS-1:0]                     i_start_x,
    input  logic [COORD_BITS-1:0]                     i_start_y,
    fdot_res_if.source                                o_res
);
    import fdot_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int WB    = CB + 1;
    localparam int AB    = 2 * CB + 2;
    localparam int CMPB  = (AB > AREA_REG_BITS) ? AB : AREA_REG_BITS;
    localparam int D2B   = 2 * CB + 1;
    localparam int RB    = CB + SPEED_FRAC_BITS + 7;
    localparam int NB    = 2 * RB;
    localparam int CNTB  = $clog2(RB + 1);
    localparam int CW    = (RB > SPEED_BITS) ? RB : SPEED_BITS;
    localparam int SB    = CB + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AREA  = 4'd1;
    localparam logic [3:0] S_FOUND = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_D2    = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // rounded centre: (2*start + len) / 2, ties to even, saturated
    function automatic logic [CB-1:0] round_ctr(input logic [CB-1:0] start,
                                                input logic [WB-1:0] len);
        logic [SB-1:0] s;
        logic [CB:0]   q;
        s = {1'b0, start, 1'b0} + SB'(len);
        q = s[SB-1:1];
        if (s[0] && q[0]) begin
            q = q + 1'b1;
        end
        return q[CB] ? '1 : q[CB-1:0];
    endfunction

    // record fields
    logic                  rec_any;
    logic [CB-1:0]         rec_min_x, rec_max_x, rec_min_y, rec_max_y;
    logic [TIME_BITS-1:0]  rec_time;

    assign rec_any   = i_rec[4*CB+TIME_BITS];
    assign rec_min_x = i_rec[TIME_BITS+4*CB-1 -: CB];
    assign rec_max_x = i_rec[TIME_BITS+3*CB-1 -: CB];
    assign rec_min_y = i_rec[TIME_BITS+2*CB-1 -: CB];
    assign rec_max_y = i_rec[TIME_BITS+CB-1 -: CB];
    assign rec_time  = i_rec[TIME_BITS-1:0];

    logic [3:0]              r_state;
    logic [CB-1:0]           r_left, r_top, r_cx, r_cy;
    logic [WB-1:0]           r_w, r_h;
    logic [TIME_BITS-1:0]    r_time, r_dt;
    logic [AB-1:0]           r_area;
    logic                    r_found;
    logic signed [CB:0]      r_dx, r_dy;
    logic [2*CB-1:0]         r_sqx, r_sqy;
    logic [D2B-1:0]          r_d2;
    logic [NB-1:0]           r_rad;
    logic [DEN_BITS-1:0]     r_den;
    logic [RB-1:0]           r_root;
    logic [RB:0]             r_rem;
    logic [CNTB-1:0]         r_cnt;
    logic [RB-1:0]           r_quo;
    logic [DEN_BITS-1:0]     r_drem;
    logic [SPEED_BITS-1:0]   r_speed;
    logic [CB-1:0]           r_prev_x, r_prev_y;
    logic [TIME_BITS-1:0]    r_prev_time;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [CB-1:0]           r_out_left, r_out_top, r_out_cx, r_out_cy;
    logic [WB-1:0]           r_out_w, r_out_h;
    logic [SPEED_BITS-1:0]   r_out_speed;

    logic                    found_c;
    logic [TIME_BITS:0]      dt_c;
    logic signed [2*CB+1:0]  sqx_c, sqy_c;
    logic [D2B-1:0]          d2_c;
    logic [D2B+RAD_SCALE_BITS-1:0] scaled_c;
    logic [DEN_BITS-1:0]     den_c;
    logic [RB+1:0]           rem_sh, trial, sqrt_diff;
    logic                    sqrt_take;
    logic [RB-1:0]           root_nx;
    logic [DEN_BITS:0]       drem_sh, div_diff;
    logic                    div_take;
    logic [RB-1:0]           quo_nx;
    logic [RB:0]             qp1;
    logic [RB-1:0]           half;
    logic [SPEED_BITS-1:0]   speed_c;
    logic                    out_free;

    assign o_pop    = (r_state == S_IDLE) && i_rec_valid;
    assign out_free = !r_out_valid || o_res.ready;

    // area window, elapsed time, squares, distance, radicand scaling and divisor
    always_comb begin
        found_c = (CMPB'(r_area) > CMPB'(i_lim.min_area)) &&
                  (CMPB'(r_area) < CMPB'(i_lim.max_area));
        dt_c    = (r_time < r_prev_time)
                ? {1'b0, r_time} + TIME_WRAP - {1'b0, r_prev_time}
                : {1'b0, r_time} - {1'b0, r_prev_time};
        sqx_c   = r_dx * r_dx;
        sqy_c   = r_dy * r_dy;
        d2_c    = D2B'(r_sqx) + D2B'(r_sqy);
        scaled_c = (D2B+RAD_SCALE_BITS)'(r_d2) * (D2B+RAD_SCALE_BITS)'(RAD_SCALE);
        den_c   = DEN_BITS'(r_dt) * DIST_DEN;
    end

    // one root bit per step
    always_comb begin
        rem_sh    = {r_rem[RB-1:0], r_rad[NB-1 -: 2]};
        trial     = {r_root, 2'b01};
        sqrt_diff = rem_sh - trial;
        sqrt_take = (rem_sh >= trial);
        root_nx   = {r_root[RB-2:0], sqrt_take};
    end

    // one quotient bit per step, then round half up and saturate
    always_comb begin
        drem_sh  = {r_drem, r_quo[RB-1]};
        div_diff = drem_sh - {1'b0, r_den};
        div_take = (drem_sh >= {1'b0, r_den});
        quo_nx   = {r_quo[RB-2:0], div_take};
        qp1      = {1'b0, quo_nx} + 1'b1;
        half     = qp1[RB:1];
        speed_c  = (CW'(half) > CW'(SPEED_MAX)) ? SPEED_MAX : SPEED_BITS'(half);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_rec_valid) begin
                        r_state <= S_AREA;
                    end
                end
                S_AREA: begin
                    r_state <= S_FOUND;
                end
                S_FOUND: begin
                    r_state <= found_c ? S_SQ : S_OUT;
                end
                S_SQ: begin
                    r_state <= S_D2;
                end
                S_D2: begin
                    r_state <= (d2_c == '0 || r_dt == '0) ? S_OUT : S_SCALE;
                end
                S_SCALE: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_cnt == CNTB'(RB - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNTB'(RB - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_left <= rec_any ? rec_min_x : '0;
                r_top  <= rec_any ? rec_min_y : '0;
                r_w    <= rec_any ? WB'(rec_max_x) - WB'(rec_min_x) + 1'b1 : '0;
                r_h    <= rec_any ? WB'(rec_max_y) - WB'(rec_min_y) + 1'b1 : '0;
                r_time <= rec_time;
            end
            S_AREA: begin
                r_area <= AB'(r_w) * AB'(r_h);
                r_cx   <= round_ctr(r_left, r_w);
                r_cy   <= round_ctr(r_top, r_h);
            end
            S_FOUND: begin
                r_found <= found_c;
                r_dx    <= $signed({1'b0, r_cx}) - $signed({1'b0, r_prev_x});
                r_dy    <= $signed({1'b0, r_cy}) - $signed({1'b0, r_prev_y});
                r_dt    <= dt_c[TIME_BITS-1:0];
            end
            S_SQ: begin
                r_sqx <= sqx_c[2*CB-1:0];
                r_sqy <= sqy_c[2*CB-1:0];
            end
            S_D2: begin
                r_d2 <= d2_c;
            end
            S_SCALE: begin
                r_rad  <= {scaled_c, {(2*SPEED_FRAC_BITS){1'b0}}};
                r_den  <= den_c;
                r_root <= '0;
                r_rem  <= '0;
            end
            S_SQRT: begin
                r_rad  <= {r_rad[NB-3:0], 2'b00};
                r_root <= root_nx;
                r_rem  <= sqrt_take ? sqrt_diff[RB:0] : rem_sh[RB:0];
                if (r_cnt == CNTB'(RB - 1)) begin
                    r_quo  <= root_nx;
                    r_drem <= '0;
                end
            end
            S_DIV: begin
                r_quo  <= quo_nx;
                r_drem <= div_take ? div_diff[DEN_BITS-1:0] : drem_sh[DEN_BITS-1:0];
            end
            default: begin
            end
        endcase
    end

    // tracked position, time and speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= CB'(START_X_RST);
            r_prev_y    <= CB'(START_Y_RST);
            r_prev_time <= '0;
            r_speed     <= '0;
        end else if (r_state == S_DIV && r_cnt == CNTB'(RB - 1)) begin
            r_speed     <= speed_c;
            r_prev_x    <= r_cx;
            r_prev_y    <= r_cy;
            r_prev_time <= r_time;
        end else begin
            if (i_load.load_x) begin
                r_prev_x <= i_start_x;
            end
            if (i_load.load_y) begin
                r_prev_y <= i_start_y;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_found <= r_found;
            r_out_left  <= r_left;
            r_out_top   <= r_top;
            r_out_w     <= r_w;
            r_out_h     <= r_h;
            r_out_cx    <= r_found ? r_cx : '0;
            r_out_cy    <= r_found ? r_cy : '0;
            r_out_speed <= r_speed;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_out_found;
    assign o_res.box_left   = r_out_left;
    assign o_res.box_top    = r_out_top;
    assign o_res.box_width  = r_out_w;
    assign o_res.box_height = r_out_h;
    assign o_res.center_x   = r_out_cx;
    assign o_res.center_y   = r_out_cy;
    assign o_res.speed_q8   = r_out_speed;

endmodule

[rtl/frame_diff_object_tracker.sv]
// frame_diff_object_tracker: top level with register block, front end,
// record queue and back end; depends on fdot_pkg, fdot_if and all fdot_ modules
//
// Pixel words are taken one per clock. The front end marks a masked pixel as
// foreground when its difference to the background exceeds diff_threshold and
// grows the bounding box; the word flagged frame_end closes the frame and one
// result word follows for it. Frame records wait in a two-entry queue, and the
// pixel side stalls for as long as both entries are taken.
// The back end takes a frame with a hit and moved centre through a
// bit-serial square root and a bit-serial divider, one bit per cycle each;
// a hit with no move or no elapsed time and a miss skip both, and every
// result then waits for the result register. Speed is in Q8 with
// SPEED_FRAC_BITS fraction bits and saturates at all ones. Registers sit on
// an APB port at byte offsets 0, 4, 8, 12, 16; writing start_x or start_y
// also moves the last tracked position. No clearing pass after reset.
module frame_diff_object_tracker #(
    parameter int COORD_BITS      = fdot_pkg::COORD_BITS_DEF,
    parameter int SPEED_FRAC_BITS = fdot_pkg::SPEED_FRAC_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fdot_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [fdot_pkg::DATA_BITS-1:0]   pwdata,
    output logic [fdot_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    fdot_pix_if.sink                         i_pix,
    fdot_res_if.source                       o_res
);
    import fdot_pkg::*;

    localparam int REC_BITS = 4 * COORD_BITS + TIME_BITS + 1;

    logic [THR_BITS-1:0]      r_thr;
    logic [AREA_REG_BITS-1:0] r_min_area, r_max_area;
    logic [COORD_BITS-1:0]    r_start_x, r_start_y;
    t_prev_load               r_load;
    t_area_lim                lim;
    logic                     wr_en;
    logic [REG_IDX_BITS-1:0]  reg_idx;

    logic                     push, full, pop, rec_valid;
    logic [REC_BITS-1:0]      rec_in, rec_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_BITS-1:2];

    // register writes, with one-cycle load strobes for the last position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RST;
            r_min_area <= MIN_AREA_RST;
            r_max_area <= MAX_AREA_RST;
            r_start_x  <= COORD_BITS'(START_X_RST);
            r_start_y  <= COORD_BITS'(START_Y_RST);
            r_load     <= '0;
        end else begin
            r_load.load_x <= wr_en && (reg_idx == REG_START_X);
            r_load.load_y <= wr_en && (reg_idx == REG_START_Y);
            if (wr_en) begin
                unique case (reg_idx)
                    REG_DIFF_THR: r_thr      <= pwdata[THR_BITS-1:0];
                    REG_MIN_AREA: r_min_area <= pwdata[AREA_REG_BITS-1:0];
                    REG_MAX_AREA: r_max_area <= pwdata[AREA_REG_BITS-1:0];
                    REG_START_X:  r_start_x  <= pwdata[COORD_BITS-1:0];
                    REG_START_Y:  r_start_y  <= pwdata[COORD_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_DIFF_THR: prdata = DATA_BITS'(r_thr);
            REG_MIN_AREA: prdata = DATA_BITS'(r_min_area);
            REG_MAX_AREA: prdata = DATA_BITS'(r_max_area);
            REG_START_X:  prdata = DATA_BITS'(r_start_x);
            REG_START_Y:  prdata = DATA_BITS'(r_start_y);
            default:      prdata = '0;
        endcase
    end

    assign lim.min_area = r_min_area;
    assign lim.max_area = r_max_area;

    fdot_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_thr   (r_thr),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (rec_in)
    );

    fdot_fifo #(
        .WIDTH (REC_BITS),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (rec_valid),
        .o_data  (rec_out)
    );

    fdot_back #(
        .COORD_BITS      (COORD_BITS),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec_out),
        .o_pop       (pop),
        .i_lim       (lim),
        .i_load      (r_load),
        .i_start_x   (r_start_x),
        .i_start_y   (r_start_y),
        .o_res       (o_res)
    );

endmodule

[tb/sv/frame_diff_object_tracker_test.sv]
// frame_diff_object_tracker_test: self-checking bench for the tracker; pixel words in,
// frame results out, registers set over the apb port and a running frame predictor
// depends on fdot_pkg, fdot_if and the frame_diff_object_tracker rtl
module frame_diff_object_tracker_test;
    import fdot_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW            = COORD_BITS_DEF;
    localparam int COORD_TOP     = (1 << CW) - 1;
    localparam int TIME_SPAN     = 1000;
    localparam longint unsigned SPEED_K  = 40 << SPEED_FRAC_DEF;
    localparam longint unsigned RAD_GAIN = 4 * SPEED_K * SPEED_K;
    localparam int SPEED_DIV     = 69;
    localparam int SPEED_Q_TOP   = 1 << 21;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 260;

    typedef struct packed {
        logic [PIX_BITS-1:0]  cur;
        logic [PIX_BITS-1:0]  bg;
        logic                 mask;
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic                 fe;
        logic [TIME_BITS-1:0] ms;
    } t_pix_word;

    typedef struct packed {
        logic                  found;
        logic [CW-1:0]         left;
        logic [CW-1:0]         top;
        logic [CW:0]           width;
        logic [CW:0]           height;
        logic [CW-1:0]         cx;
        logic [CW-1:0]         cy;
        logic [SPEED_BITS-1:0] speed;
    } t_frame_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    fdot_pix_if pix_if ();
    fdot_res_if res_if ();

    frame_diff_object_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    // stimulus and expectation stores
    t_pix_word     pixel_queue[$];
    t_frame_result expected_frames[$];

    // predictor copy of registers and tracking state
    int thr_q, min_area_q, max_area_q;
    int fg_min_x, fg_max_x, fg_min_y, fg_max_y;
    bit fg_seen;
    int last_x, last_y, last_ms, speed_q;

    // handshake and idling control
    bit pix_fire;
    bit idle_on;
    int tx_gap, rx_gap, rx_long;
    int stall_cycles;
    int mismatches;

    // random frame generator state
    int box_x, box_y, box_w, box_h;
    int frame_ms;
    int pixels_queued;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_box();
        fg_min_x = COORD_TOP;
        fg_min_y = COORD_TOP;
        fg_max_x = 0;
        fg_max_y = 0;
        fg_seen  = 1'b0;
    endfunction

    function automatic void reset_tracker();
        thr_q      = int'(THR_RST);
        min_area_q = int'(MIN_AREA_RST);
        max_area_q = int'(MAX_AREA_RST);
        last_x     = START_X_RST;
        last_y     = START_Y_RST;
        last_ms    = 0;
        speed_q    = 0;
        clear_box();
    endfunction

    // half-to-even center of a span, clipped to the last coordinate
    function automatic int rounded_center(int start, int len);
        int s;
        int q;
        s = 2 * start + len;
        q = s >> 1;
        if ((s & 1) && (q & 1))
            q++;
        return (q > COORD_TOP) ? COORD_TOP : q;
    endfunction

    // round_half_up(sqrt(d2) * K / (69 * dt)): search the largest q with
    // (q * den)^2 <= 4 * K^2 * d2, then halve with rounding
    function automatic int speed_estimate(longint unsigned d2, int dt);
        logic [127:0]    rhs;
        logic [127:0]    prod;
        longint unsigned den;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        int unsigned     n;
        den = longint'(SPEED_DIV * dt);
        rhs = 128'(RAD_GAIN) * 128'(d2);
        lo  = 0;
        hi  = SPEED_Q_TOP;
        while (lo < hi) begin
            mid  = lo + (hi - lo + 1) / 2;
            prod = 128'(mid) * 128'(den);
            prod = prod * prod;
            if (prod <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        n = (lo + 1) / 2;
        return (n > SPEED_MAX) ? int'(SPEED_MAX) : int'(n);
    endfunction

    // grows the box per accepted word; a frame end yields one expected result
    task automatic track_pixel(t_pix_word p);
        int              diff;
        int              ms;
        int              dx;
        int              dy;
        int              dt;
        longint unsigned area;
        longint unsigned d2;
        t_frame_result   r;
        diff = (p.cur > p.bg) ? int'(p.cur) - int'(p.bg) : int'(p.bg) - int'(p.cur);
        if (p.mask && diff > thr_q) begin
            if (int'(p.x) < fg_min_x) fg_min_x = int'(p.x);
            if (int'(p.x) > fg_max_x) fg_max_x = int'(p.x);
            if (int'(p.y) < fg_min_y) fg_min_y = int'(p.y);
            if (int'(p.y) > fg_max_y) fg_max_y = int'(p.y);
            fg_seen = 1'b1;
        end
        if (!p.fe)
            return;
        ms = (p.ms > TIME_LAST) ? int'(TIME_LAST) : int'(p.ms);
        r  = '0;
        if (fg_seen) begin
            r.left   = CW'(fg_min_x);
            r.top    = CW'(fg_min_y);
            r.width  = (CW+1)'(fg_max_x - fg_min_x + 1);
            r.height = (CW+1)'(fg_max_y - fg_min_y + 1);
        end
        area    = longint'(r.width) * longint'(r.height);
        r.found = (area > min_area_q) && (area < max_area_q);
        if (r.found) begin
            r.cx = CW'(rounded_center(int'(r.left), int'(r.width)));
            r.cy = CW'(rounded_center(int'(r.top), int'(r.height)));
            dx   = int'(r.cx) - last_x;
            dy   = int'(r.cy) - last_y;
            d2   = longint'(dx * dx) + longint'(dy * dy);
            dt   = (ms < last_ms) ? ms + TIME_SPAN - last_ms : ms - last_ms;
            if (d2 != 0 && dt != 0) begin
                speed_q = speed_estimate(d2, dt);
                last_x  = int'(r.cx);
                last_y  = int'(r.cy);
                last_ms = ms;
            end
        end
        r.speed = SPEED_BITS'(speed_q);
        expected_frames = {expected_frames, r};
        clear_box();
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // accept side: predict on pixel words, compare result words, watchdog
    always @(posedge i_clk) begin : monitor
        t_frame_result got;
        t_frame_result want;
        pix_fire = i_rst_n && pix_if.valid && pix_if.ready;
        if (pix_fire)
            track_pixel({pix_if.current_pixel, pix_if.background_pixel, pix_if.in_mask,
                         pix_if.pixel_x, pix_if.pixel_y, pix_if.frame_end, pix_if.time_ms});
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.found, res_if.box_left, res_if.box_top, res_if.box_width,
                   res_if.box_height, res_if.center_x, res_if.center_y, res_if.speed_q8};
            if (expected_frames.size() == 0) begin
                $error("result word with no frame pending");
                mismatches++;
            end else begin
                want = expected_frames.pop_front();
                check_field("found", want.found, got.found);
                check_field("box_left", want.left, got.left);
                check_field("box_top", want.top, got.top);
                check_field("box_width", want.width, got.width);
                check_field("box_height", want.height, got.height);
                check_field("center_x", want.cx, got.cx);
                check_field("center_y", want.cy, got.cy);
                check_field("speed_q8", want.speed, got.speed);
            end
        end
        // watchdog on cycles with no accepted word or register access
        if (pix_fire || (i_rst_n && res_if.valid && res_if.ready) ||
            (psel && penable && pready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("frame_diff_object_tracker verification failed");
            $finish;
        end
    end

    // pixel word driver with random idle bursts
    always @(negedge i_clk) begin : driver
        t_pix_word nxt;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (pix_if.valid && !pix_fire) begin
            // word still on offer
        end else if (tx_gap > 0) begin
            tx_gap--;
            pix_if.valid <= 1'b0;
        end else if (pixel_queue.size() == 0) begin
            pix_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            tx_gap = $urandom_range(0, 11);
            pix_if.valid <= 1'b0;
        end else begin
            nxt = pixel_queue.pop_front();
            pix_if.current_pixel    <= nxt.cur;
            pix_if.background_pixel <= nxt.bg;
            pix_if.in_mask          <= nxt.mask;
            pix_if.pixel_x          <= nxt.x;
            pix_if.pixel_y          <= nxt.y;
            pix_if.frame_end        <= nxt.fe;
            pix_if.time_ms          <= nxt.ms;
            pix_if.valid            <= 1'b1;
        end
    end

    // result receiver: long hold when requested, else random stall bursts
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (rx_long > 0) begin
            rx_long--;
            res_if.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 11);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // apb write: setup then access, register taken at the access edge
    task automatic write_register(logic [REG_IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_DIFF_THR: thr_q = int'(value[THR_BITS-1:0]);
            REG_MIN_AREA: min_area_q = int'(value[AREA_REG_BITS-1:0]);
            REG_MAX_AREA: max_area_q = int'(value[AREA_REG_BITS-1:0]);
            REG_START_X:  last_x = int'(value[CW-1:0]);
            REG_START_Y:  last_y = int'(value[CW-1:0]);
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_tracking_config(int thr, int min_a, int max_a, int sx, int sy);
        write_register(REG_DIFF_THR, DATA_BITS'(thr));
        write_register(REG_MIN_AREA, DATA_BITS'(min_a));
        write_register(REG_MAX_AREA, DATA_BITS'(max_a));
        write_register(REG_START_X, DATA_BITS'(sx));
        write_register(REG_START_Y, DATA_BITS'(sy));
    endtask

    // block until every word is taken and every frame answered, then let it settle
    task automatic drain_results();
        while (pixel_queue.size() != 0 || pix_if.valid || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_pix_word make_pixel(int cur, int bg, bit mask, int x, int y,
                                             bit fe, int ms);
        t_pix_word p;
        p.cur  = PIX_BITS'(cur);
        p.bg   = PIX_BITS'(bg);
        p.mask = mask;
        p.x    = CW'(x);
        p.y    = CW'(y);
        p.fe   = fe;
        p.ms   = TIME_BITS'(ms);
        return p;
    endfunction

    // append a word to the stimulus queue
    function automatic void queue_word(t_pix_word p);
        pixel_queue = {pixel_queue, p};
    endfunction

    // masked pixel whose difference exceeds the current threshold (255 if the threshold is 255)
    function automatic t_pix_word fg_pixel(int x, int y);
        int diff;
        int bg;
        diff = (thr_q < 255) ? $urandom_range(thr_q + 1, 255) : 255;
        bg   = $urandom_range(0, 255 - diff);
        if ($urandom_range(0, 1))
            return make_pixel(bg + diff, bg, 1'b1, x, y, 1'b0, $urandom_range(0, 1023));
        return make_pixel(bg, bg + diff, 1'b1, x, y, 1'b0, $urandom_range(0, 1023));
    endfunction

    // masked pixel at or under the threshold
    function automatic t_pix_word quiet_pixel(int x, int y);
        int diff;
        int bg;
        diff = $urandom_range(0, thr_q);
        bg   = $urandom_range(0, 255 - diff);
        if ($urandom_range(0, 1))
            return make_pixel(bg + diff, bg, 1'b1, x, y, 1'b0, $urandom_range(0, 1023));
        return make_pixel(bg, bg + diff, 1'b1, x, y, 1'b0, $urandom_range(0, 1023));
    endfunction

    // two foreground corners, the second closing the frame
    task automatic queue_box_frame(int l, int t, int r, int b, int ms);
        t_pix_word p;
        queue_word(fg_pixel(l, t));
        p    = fg_pixel(r, b);
        p.fe = 1'b1;
        p.ms = TIME_BITS'(ms);
        queue_word(p);
    endtask

    // frame stamp: mostly advancing, sometimes repeated or out of range
    function automatic int next_frame_ms();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(TIME_SPAN, 1023);
        if (r < 3)
            return frame_ms;
        frame_ms = (frame_ms + $urandom_range(1, 400)) % TIME_SPAN;
        return frame_ms;
    endfunction

    // one well-formed frame around a random box, now and then with no foreground, with quiet, unmasked and stray pixels
    task automatic queue_random_frame();
        int        n;
        int        ia;
        int        ib;
        int        kind;
        int        ms;
        bit        empty;
        t_pix_word p;
        empty = ($urandom_range(0, 11) == 0);
        if ($urandom_range(0, 6) != 0) begin
            if ($urandom_range(0, 19) == 0) begin
                box_w = $urandom_range(1, COORD_TOP + 1);
                box_h = $urandom_range(1, COORD_TOP + 1);
            end else begin
                box_w = $urandom_range(1, 400);
                box_h = $urandom_range(1, 400);
            end
            box_x = $urandom_range(0, COORD_TOP + 1 - box_w);
            box_y = $urandom_range(0, COORD_TOP + 1 - box_h);
        end
        n  = $urandom_range(2, 8);
        ia = $urandom_range(0, n - 1);
        ib = $urandom_range(0, n - 1);
        ms = next_frame_ms();
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            if (!empty && i == ia)
                p = fg_pixel(box_x, box_y);
            else if (!empty && i == ib)
                p = fg_pixel(box_x + box_w - 1, box_y + box_h - 1);
            else if (!empty && kind < 3)
                p = fg_pixel(box_x + $urandom_range(0, box_w - 1),
                             box_y + $urandom_range(0, box_h - 1));
            else if (kind < 6 || (empty && kind == 9))
                p = quiet_pixel($urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
            else if (kind < 9)
                p = make_pixel($urandom_range(0, 255), $urandom_range(0, 255), 1'b0,
                               $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP),
                               1'b0, $urandom_range(0, 1023));
            else
                p = fg_pixel($urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
            if (i == n - 1) begin
                p.fe = 1'b1;
                p.ms = TIME_BITS'(ms);
            end
            queue_word(p);
            pixels_queued++;
        end
    endtask

    task automatic queue_random_pixels(int count);
        pixels_queued = 0;
        while (pixels_queued < count)
            queue_random_frame();
    endtask

    initial begin
        reset_tracker();
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        pix_if.valid            = 1'b0;
        pix_if.current_pixel    = '0;
        pix_if.background_pixel = '0;
        pix_if.in_mask          = 1'b0;
        pix_if.pixel_x          = '0;
        pix_if.pixel_y          = '0;
        pix_if.frame_end        = 1'b0;
        pix_if.time_ms          = '0;
        res_if.ready            = 1'b0;
        idle_on                 = 1'b1;
        box_x = 0;
        box_y = 0;
        box_w = 1;
        box_h = 1;
        frame_ms = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: ignored word, empty frame, threshold edge, hits and misses
        queue_word(make_pixel(255, 0, 1'b0, COORD_TOP, COORD_TOP, 1'b0, 1023));
        queue_word(make_pixel(77, 77, 1'b1, 0, 0, 1'b1, 0));
        queue_word(make_pixel(120, 100, 1'b1, 10, 10, 1'b0, 0));
        queue_word(make_pixel(0, 21, 1'b1, 100, 200, 1'b0, 0));
        queue_box_frame(100, 200, 149, 239, 300);
        // same box again: zero distance keeps the speed
        queue_box_frame(100, 200, 149, 239, 500);
        // same stamp as the last move: zero elapsed time
        queue_box_frame(300, 300, 339, 339, 300);
        // stamp out of range
        queue_box_frame(500, 500, 549, 529, 1020);
        // stamp wraps, odd spans round half to even
        queue_box_frame(0, 0, 34, 32, 10);
        // area on the lower limit, over the upper limit, just under it
        queue_box_frame(0, 0, 39, 24, 50);
        queue_box_frame(0, 0, 299, 299, 60);
        queue_box_frame(1000, 1000, 1298, 1199, 200);
        drain_results();

        // widest limits: full-frame box, center clipped at the corner
        set_tracking_config(0, 0, 32'h1FF_FFFF, 0, COORD_TOP);
        queue_box_frame(0, 0, COORD_TOP, COORD_TOP, 0);
        queue_word(make_pixel(200, 3, 1'b1, COORD_TOP, COORD_TOP, 1'b1, 700));
        queue_word(make_pixel(9, 9, 1'b1, 5, 5, 1'b1, 999));
        drain_results();

        // closed limits and top threshold: nothing can be foreground or found
        set_tracking_config(255, 32'h1FF_FFFF, 0, COORD_TOP, 0);
        queue_word(make_pixel(255, 0, 1'b1, 7, 7, 1'b1, 3));
        queue_random_pixels(40);
        drain_results();

        // random phases, idling only in the even ones and never in the last
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 4)
                set_tracking_config($urandom_range(0, 60), 0, 32'h1FF_FFFF,
                                    $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
            else begin
                min_area_q = $urandom_range(0, 20000);
                set_tracking_config($urandom_range(0, 60), min_area_q,
                                    min_area_q + $urandom_range(20000, 400000),
                                    $urandom_range(0, COORD_TOP), $urandom_range(0, COORD_TOP));
            end
            idle_on = (ph % 2 == 0) && (ph != RANDOM_PHASES - 1);
            if (ph == 2) begin
                @(posedge i_clk);
                rx_long = 400;
            end
            queue_random_pixels(PHASE_PIXELS);
            drain_results();
        end

        if (expected_frames.size() != 0) begin
            $error("%0d frame results never arrived", expected_frames.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("frame_diff_object_tracker verification clean");
        else
            $display("frame_diff_object_tracker verification failed");
        $finish;
    end

endmodule
